// ----- design/dewu_pkg.sv -----
`timescale 1ns / 1ps

package dewu_pkg;

	localparam int unsigned HEADER_WORDS = 4;
	localparam int unsigned MAX_CHANNELS = 8;
	localparam int unsigned LEN_W        = 28;
	localparam int unsigned QUEUE_DEPTH  = 4;

	localparam logic MODE_8BIT  = 1'b0;
	localparam logic MODE_16BIT = 1'b1;

	localparam logic REG_SAMPLE_MODE = 1'b0;

	// One payload word with everything the back end needs to unpack it.
	typedef struct packed {
		logic [31:0]      word;
		logic             mode;
		logic [2:0]       block;
		logic [LEN_W-1:0] wib;
		logic             blk_end;
		logic             ev_end;
	} dewu_entry_t;

	typedef struct packed {
		logic             start;
		logic [LEN_W-1:0] dividend;
		logic [3:0]       divisor;
	} dewu_div_req_t;

	typedef struct packed {
		logic             busy;
		logic [LEN_W-1:0] quotient;
	} dewu_div_rsp_t;

	// Number of set bits among the low channel-mask bits.
	function automatic logic [3:0] count_blocks(input logic [31:0] w);
		logic [3:0] n;
		n = 4'd0;
		for (int i = 0; i < 8; i++) begin
			if (i < MAX_CHANNELS) begin
				n = n + {3'b000, w[i]};
			end
		end
		return n;
	endfunction

endpackage

// ----- design/digitizer_event_waveform_unpacker_core.sv -----
`timescale 1ns / 1ps
// A payload word passes from the input through a queue slot and the back end's word register into the
// output register. The one-sample output port sets the pace: four samples per payload word with 8-bit
// samples, two with 16-bit samples. After header word 1 is taken the input stalls while the bit-serial
// divider works out the block size.
// Reset (arst_n low) clears all control state and sets sample_mode to 8-bit samples.
module digitizer_event_waveform_unpacker_core (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] data_word
	// Output stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // [15:0] sample, [18:16] block_index,
	                               // [48:19] sample_position, [55:49] zero
	output logic [1:0]  m_tuser,   // [0] block_end, [1] event_end
	output logic        m_tlast,   // last sample taken from its input word
	// Configuration port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// The register index is the word address; only the sample mode register exists.
	logic sample_mode_q;
	logic cfg_write;
	logic cfg_hit;

	assign pready    = 1'b1;
	assign cfg_hit   = paddr[2] == dewu_pkg::REG_SAMPLE_MODE;
	assign cfg_write = psel && penable && pwrite && pready;
	assign prdata    = cfg_hit ? {31'd0, sample_mode_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_mode_q <= dewu_pkg::MODE_8BIT;
		end else if (cfg_write && cfg_hit) begin
			sample_mode_q <= pwdata[0];
		end
	end

	// The front end parses headers and tags payload words; the queue lets it keep
	// taking words while the back end is still emitting samples of earlier ones.
	dewu_pkg::dewu_div_req_t div_req;
	dewu_pkg::dewu_div_rsp_t div_rsp;
	dewu_pkg::dewu_entry_t   push_entry;
	dewu_pkg::dewu_entry_t   pop_entry;
	logic                    q_push;
	logic                    q_full;
	logic                    q_valid;
	logic                    q_pop;

	dewu_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	dewu_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.sample_mode (sample_mode_q),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_entry     (push_entry),
		.div_req     (div_req),
		.div_rsp     (div_rsp)
	);

	dewu_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (push_entry),
		.full       (q_full),
		.valid      (q_valid),
		.pop_entry  (pop_entry),
		.pop        (q_pop)
	);

	// The back end turns each queued word into two or four samples.
	dewu_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_entry  (pop_entry),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// No word may be taken while the block size is still being computed.
	assert property (@(posedge clk) disable iff (!arst_n) div_rsp.busy |-> !s_tready)
		else $error("input accepted while divider busy");

	// A word is pushed only when the queue has room.
	assert property (@(posedge clk) disable iff (!arst_n) q_push |-> !q_full)
		else $error("queue overflow");

	// Event end marks the last block end, which falls on the last sample of a word.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[1]) |-> (m_tuser[0] && m_tlast))
		else $error("event end without block end");

	// Right after header word 1 is taken the divider is running.
	assert property (@(posedge clk) disable iff (!arst_n) div_req.start |=> div_rsp.busy)
		else $error("divider did not start");

endmodule

// ----- design/dewu_div.sv -----
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle. The divisor is at most 8, so
// the partial remainder fits in three bits.
module dewu_div (
	input  logic                    clk,
	input  logic                    arst_n,
	input  dewu_pkg::dewu_div_req_t req,
	output dewu_pkg::dewu_div_rsp_t rsp
);

	localparam int unsigned CNT_W = $clog2(dewu_pkg::LEN_W);

	logic                       busy_q;
	logic [CNT_W-1:0]           cnt_q;
	logic [dewu_pkg::LEN_W-1:0] quo_q;
	logic [2:0]                 rem_q;
	logic [3:0]                 dvs_q;
	logic [3:0]                 trial;
	logic                       fits;

	assign trial = {rem_q, quo_q[dewu_pkg::LEN_W-1]};
	assign fits  = trial >= dvs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			quo_q  <= '0;
			rem_q  <= '0;
			dvs_q  <= 4'd1;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
			quo_q  <= req.dividend;
			rem_q  <= '0;
			dvs_q  <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[dewu_pkg::LEN_W-2:0], fits};
			rem_q <= fits ? 3'(trial - dvs_q) : trial[2:0];
			if (cnt_q == CNT_W'(dewu_pkg::LEN_W - 1)) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q + 1'b1;
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.quotient = quo_q;

endmodule

// ----- design/dewu_front.sv -----
`timescale 1ns / 1ps

// Walks the event header, tracks block and word position, and forwards
// every payload word that produces samples to the queue.
module dewu_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  logic [31:0]             s_tdata,
	input  logic                    sample_mode,
	input  logic                    q_full,
	output logic                    q_push,
	output dewu_pkg::dewu_entry_t   q_entry,
	output dewu_pkg::dewu_div_req_t div_req,
	input  dewu_pkg::dewu_div_rsp_t div_rsp
);

	localparam int unsigned LW = dewu_pkg::LEN_W;
	localparam logic [LW-1:0] HDR = LW'(dewu_pkg::HEADER_WORDS);

	logic [LW-1:0] word_pos_q;
	logic [LW-1:0] event_len_q;
	logic [3:0]    active_q;
	logic [2:0]    cur_block_q;
	logic [LW-1:0] wib_q;
	logic          done_q;

	logic          accept;
	logic [LW-1:0] wpb;
	logic [LW-1:0] len_now;
	logic [LW-1:0] span;
	logic          wrap;
	logic          emit;
	logic          blk_end;
	logic          ev_end;
	logic [3:0]    blocks;

	assign s_tready = !div_rsp.busy && !q_full;
	assign accept   = s_tvalid && s_tready;
	assign wpb      = div_rsp.quotient;
	assign blocks   = dewu_pkg::count_blocks(s_tdata);

	// The length written by header word 0 already sets the span of its event.
	assign len_now = (word_pos_q == '0) ? s_tdata[LW-1:0] : event_len_q;
	assign span    = (len_now > HDR) ? len_now : HDR;
	assign wrap    = ({1'b0, word_pos_q} + 1'b1) >= {1'b0, span};

	assign emit    = (word_pos_q >= HDR) && !done_q && (wpb != '0)
	                 && ({1'b0, cur_block_q} < active_q);
	assign blk_end = ({1'b0, wib_q} + 1'b1) == {1'b0, wpb};
	assign ev_end  = blk_end && (({1'b0, cur_block_q} + 4'd1) == active_q);

	// Block size is found by the divider; an empty mask or a short event
	// divides zero so that the block size comes out as zero.
	always_comb begin
		div_req.start    = accept && (word_pos_q == LW'(1));
		div_req.divisor  = (blocks == 4'd0) ? 4'd1 : blocks;
		div_req.dividend = ((blocks != 4'd0) && (event_len_q >= HDR))
		                   ? (event_len_q - HDR) : '0;
	end

	assign q_push          = accept && emit;
	assign q_entry.word    = s_tdata;
	assign q_entry.mode    = sample_mode;
	assign q_entry.block   = cur_block_q;
	assign q_entry.wib     = wib_q;
	assign q_entry.blk_end = blk_end;
	assign q_entry.ev_end  = ev_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_pos_q  <= '0;
			event_len_q <= '0;
			active_q    <= '0;
			cur_block_q <= '0;
			wib_q       <= '0;
			done_q      <= 1'b0;
		end else if (accept) begin
			if (word_pos_q == '0) begin
				event_len_q <= s_tdata[LW-1:0];
				active_q    <= '0;
				cur_block_q <= '0;
				wib_q       <= '0;
				done_q      <= 1'b0;
			end else if (word_pos_q == LW'(1)) begin
				active_q <= blocks;
			end else if (emit) begin
				if (blk_end) begin
					wib_q <= '0;
					if (ev_end) begin
						done_q <= 1'b1;
					end else begin
						cur_block_q <= cur_block_q + 3'd1;
					end
				end else begin
					wib_q <= wib_q + 1'b1;
				end
			end
			word_pos_q <= wrap ? '0 : word_pos_q + 1'b1;
		end
	end

endmodule

// ----- design/dewu_queue.sv -----
`timescale 1ns / 1ps

// Small first-in first-out buffer between the front and the back end.
module dewu_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  dewu_pkg::dewu_entry_t push_entry,
	output logic                  full,
	output logic                  valid,
	output dewu_pkg::dewu_entry_t pop_entry,
	input  logic                  pop
);

	localparam int unsigned DEPTH = dewu_pkg::QUEUE_DEPTH;
	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	dewu_pkg::dewu_entry_t slots_q [DEPTH];
	logic [PTR_W-1:0]      wr_ptr_q;
	logic [PTR_W-1:0]      rd_ptr_q;
	logic [CNT_W-1:0]      count_q;
	logic                  do_push;
	logic                  do_pop;

	assign full      = count_q == CNT_W'(DEPTH);
	assign valid     = count_q != '0;
	assign pop_entry = slots_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- design/dewu_back.sv -----
`timescale 1ns / 1ps

// Splits one queued word into its samples, one per cycle while the output is not stalled, into
// the output register.
module dewu_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	input  dewu_pkg::dewu_entry_t q_entry,
	output logic                  q_pop,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [55:0]           m_tdata,
	output logic [1:0]            m_tuser,
	output logic                  m_tlast
);

	dewu_pkg::dewu_entry_t ent_q;
	logic                  ent_valid_q;
	logic [1:0]            lane_q;
	logic                  out_valid_q;
	logic [15:0]           sample_q;
	logic [2:0]            block_q;
	logic [29:0]           pos_q;
	logic                  last_q;
	logic                  blk_end_q;
	logic                  ev_end_q;

	logic                  adv;
	logic                  last_lane;
	logic                  load;
	logic [4:0]            shamt;
	logic [31:0]           shifted;
	logic [15:0]           sample;
	logic [29:0]           pos;

	assign adv       = ent_valid_q && (!out_valid_q || m_tready);
	assign last_lane = (ent_q.mode == dewu_pkg::MODE_16BIT) ? lane_q[0] : (lane_q == 2'd3);
	assign load      = q_valid && (!ent_valid_q || (adv && last_lane));
	assign q_pop     = load;

	always_comb begin
		if (ent_q.mode == dewu_pkg::MODE_16BIT) begin
			shamt  = {lane_q[0], 4'b0000};
			pos    = {1'b0, ent_q.wib, lane_q[0]};
		end else begin
			shamt  = {lane_q, 3'b000};
			pos    = {ent_q.wib, lane_q};
		end
		shifted = ent_q.word >> shamt;
		sample  = (ent_q.mode == dewu_pkg::MODE_16BIT) ? shifted[15:0]
		          : {8'h00, shifted[7:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_valid_q <= 1'b0;
			lane_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				ent_valid_q <= 1'b1;
				lane_q      <= '0;
			end else if (adv && last_lane) begin
				ent_valid_q <= 1'b0;
			end else if (adv) begin
				lane_q <= lane_q + 2'd1;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ent_q <= q_entry;
		end
		if (adv) begin
			sample_q  <= sample;
			block_q   <= ent_q.block;
			pos_q     <= pos;
			last_q    <= last_lane;
			blk_end_q <= last_lane && ent_q.blk_end;
			ev_end_q  <= last_lane && ent_q.ev_end;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'b0000000, pos_q, block_q, sample_q};
	assign m_tuser  = {ev_end_q, blk_end_q};
	assign m_tlast  = last_q;

endmodule
